[hw/rtl/crb_pkg.sv]
`timescale 1ns / 1ps

package crb_pkg;

   // Default sizes of the bridge.
   localparam int LINK_LATENCY_DEF = 4;
   localparam int BUF_DEPTH_DEF    = 16;
   localparam int CREDIT_DEPTH_DEF = 16;
   localparam int FLIT_BITS_DEF    = 64;

   // Fixed widths of the request and response fields.
   localparam int FLIT_FIELD_BITS   = 64;
   localparam int CREDIT_FIELD_BITS = 5;
   localparam int CSR_INDEX_BITS    = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOCAL_BIDIR  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REMOTE_BIDIR = 2'd1;

   typedef struct packed {
      logic                       local_cw_occupied;
      logic                       local_cw_to_remote;
      logic [FLIT_FIELD_BITS-1:0] local_cw_flit;
      logic                       local_ccw_occupied;
      logic                       local_ccw_to_remote;
      logic [FLIT_FIELD_BITS-1:0] local_ccw_flit;
      logic                       remote_cw_busy;
      logic                       remote_ccw_busy;
      logic                       reserved_head_valid;
      logic [FLIT_FIELD_BITS-1:0] reserved_head_flit;
   } crb_req_type;

   typedef struct packed {
      logic                         local_cw_taken;
      logic                         local_ccw_taken;
      logic                         inject_valid;
      logic                         inject_ccw;
      logic [FLIT_FIELD_BITS-1:0]   inject_flit;
      logic                         reserved_pop;
      logic [CREDIT_FIELD_BITS-1:0] credits_left;
   } crb_rsp_type;

   // Per-cycle control of one queue: two ordered pushes and one pop.
   typedef struct packed {
      logic push0;
      logic push1;
      logic pop;
   } crb_qctrl_type;

endpackage

[hw/rtl/crb_queue.sv]
`timescale 1ns / 1ps

// Queue held in two interleaved memory banks so that two pushes can land in one
// cycle. The next head entry is read into a register ahead of its use, with a
// bypass when the head is written in the same cycle.
module crb_queue #(
   parameter int DEPTH = crb_pkg::BUF_DEPTH_DEF,
   parameter int WIDTH = crb_pkg::FLIT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  crb_pkg::crb_qctrl_type     ctrl,
   input  logic [WIDTH-1:0]           push0_data,
   input  logic [WIDTH-1:0]           push1_data,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic [WIDTH-1:0]           head_data
);

   localparam int BANK_ROWS = ((DEPTH + 1) / 2 < 2) ? 2 : (DEPTH + 1) / 2;
   localparam int ROW_BITS  = $clog2(BANK_ROWS);
   localparam int PTR_BITS  = ROW_BITS + 1;
   localparam int RING      = 2 * BANK_ROWS;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   function automatic logic [PTR_BITS-1:0] ptr_step(input logic [PTR_BITS-1:0] ptr,
                                                    input logic [1:0] inc);
      logic [PTR_BITS:0] sum;
      sum = {1'b0, ptr} + (PTR_BITS + 1)'(inc);
      if (sum >= (PTR_BITS + 1)'(RING)) begin
         sum = sum - (PTR_BITS + 1)'(RING);
      end
      return sum[PTR_BITS-1:0];
   endfunction

   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [PTR_BITS-1:0] tail_ff, tail_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0] wptr0, wptr1;
   logic [1:0]          push_num;

   logic [WIDTH-1:0]    bank0_ff [BANK_ROWS];
   logic [WIDTH-1:0]    bank1_ff [BANK_ROWS];
   logic                we0, we1;
   logic [ROW_BITS-1:0] wrow0, wrow1;
   logic [WIDTH-1:0]    wdat0, wdat1;
   logic [ROW_BITS-1:0] rrow;
   logic [WIDTH-1:0]    rd0_ff, rd1_ff;
   logic                rd_bank_ff;
   logic                fwd_valid_ff, fwd_valid_in;
   logic [WIDTH-1:0]    fwd_data_ff, fwd_data_in;

   assign push_num = 2'(ctrl.push0) + 2'(ctrl.push1);
   assign head_in  = ctrl.pop ? ptr_step(head_ff, 2'd1) : head_ff;
   assign tail_in  = ptr_step(tail_ff, push_num);
   assign count_in = count_ff + CNT_BITS'(ctrl.push0) + CNT_BITS'(ctrl.push1)
                     - CNT_BITS'(ctrl.pop);
   assign wptr0    = tail_ff;
   assign wptr1    = ctrl.push0 ? ptr_step(tail_ff, 2'd1) : tail_ff;
   assign rrow     = head_in[PTR_BITS-1:1];

   // Consecutive pointers alternate banks, so the two pushes never collide.
   always_comb begin
      we0   = 1'b0;
      we1   = 1'b0;
      wrow0 = '0;
      wrow1 = '0;
      wdat0 = '0;
      wdat1 = '0;
      if (ctrl.push0) begin
         if (wptr0[0]) begin
            we1   = 1'b1;
            wrow1 = wptr0[PTR_BITS-1:1];
            wdat1 = push0_data;
         end else begin
            we0   = 1'b1;
            wrow0 = wptr0[PTR_BITS-1:1];
            wdat0 = push0_data;
         end
      end
      if (ctrl.push1) begin
         if (wptr1[0]) begin
            we1   = 1'b1;
            wrow1 = wptr1[PTR_BITS-1:1];
            wdat1 = push1_data;
         end else begin
            we0   = 1'b1;
            wrow0 = wptr1[PTR_BITS-1:1];
            wdat0 = push1_data;
         end
      end
   end

   // A write to the entry that becomes the head is passed straight on.
   always_comb begin
      fwd_valid_in = 1'b0;
      fwd_data_in  = push0_data;
      if (ctrl.push1 && (wptr1 == head_in)) begin
         fwd_valid_in = 1'b1;
         fwd_data_in  = push1_data;
      end else if (ctrl.push0 && (wptr0 == head_in)) begin
         fwd_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         bank0_ff[wrow0] <= wdat0;
      end
      rd0_ff <= bank0_ff[rrow];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         bank1_ff[wrow1] <= wdat1;
      end
      rd1_ff <= bank1_ff[rrow];
   end

   always_ff @(posedge clock) begin
      rd_bank_ff  <= head_in[0];
      fwd_data_ff <= fwd_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   assign count     = count_ff;
   assign head_data = fwd_valid_ff ? fwd_data_ff : (rd_bank_ff ? rd1_ff : rd0_ff);

endmodule

[hw/rtl/credit_ring_bridge_unit.sv]
`timescale 1ns / 1ps

// The response to an accepted request is registered in the output register.
// Throughput: one request per cycle unless rsp_ready stalls the output, limited by the
// queue head pointers, whose next entry is read from memory while the current head is used.
// Reset is synchronous: both queues empty, link stages invalid, credit line clear, credit
// count at CREDIT_DEPTH, both rings bidirectional. No clearing pass is needed.
module credit_ring_bridge_unit #(
   parameter int LINK_LATENCY = crb_pkg::LINK_LATENCY_DEF,
   parameter int BUF_DEPTH    = crb_pkg::BUF_DEPTH_DEF,
   parameter int CREDIT_DEPTH = crb_pkg::CREDIT_DEPTH_DEF,
   parameter int FLIT_BITS    = crb_pkg::FLIT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  crb_pkg::crb_req_type                req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output crb_pkg::crb_rsp_type                rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic                                csr_wdata
);

   localparam int CNT_BITS = $clog2(BUF_DEPTH + 1);
   localparam int CC_BITS  = $clog2(CREDIT_DEPTH + 1);
   localparam int LAST     = LINK_LATENCY - 1;

   // Each accepted request is one tick of the ring clock. Ring state moves only on a tick.
   logic step;

   // Configuration registers.
   logic local_bidir_ff;
   logic remote_bidir_ff;

   // Elastic link: one valid bit and one flit per stage.
   logic [LINK_LATENCY-1:0] link_valid_ff, link_valid_in;
   logic [FLIT_BITS-1:0]    link_flit_ff [LINK_LATENCY];
   logic [FLIT_BITS-1:0]    link_flit_in [LINK_LATENCY];
   logic [LINK_LATENCY-1:0] free_vec;

   // Credit return delay line and the sender's credit counter.
   logic [LINK_LATENCY-1:0] credit_line_ff, credit_line_in;
   logic [CC_BITS-1:0]      credit_count_ff, credit_count_in, credit_mid;
   logic                    credit_ret;

   // Queue interfaces.
   crb_pkg::crb_qctrl_type  arr_ctrl, ej_ctrl;
   logic [CNT_BITS-1:0]     arr_count, ej_count;
   logic [FLIT_BITS-1:0]    arr_head, ej_head;
   logic [CNT_BITS-1:0]     arr_after, ej_after, ej_after_cw;

   // Decisions of this tick.
   logic inj_cw, inj_ccw, arr_pop, arr_push;
   logic can_send, send_res, ej_pop, send;
   logic [FLIT_BITS-1:0] send_flit;
   logic cw_take, ccw_take;

   // Output register.
   logic                 rsp_valid_ff;
   crb_pkg::crb_rsp_type rsp_data_ff, rsp_in;

   // The output register frees its slot in the same cycle that its response is taken, so a
   // new request can follow at full rate whenever rsp_ready is high, also right after a stall.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_bidir_ff  <= 1'b1;
         remote_bidir_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            crb_pkg::CSR_LOCAL_BIDIR: begin
               local_bidir_ff <= csr_wdata;
            end
            crb_pkg::CSR_REMOTE_BIDIR: begin
               remote_bidir_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Far end. The head of the arrival queue goes clockwise if that slot is free, otherwise
   // counterclockwise when the remote ring allows it. A flit leaving the link is admitted only
   // if the arrival queue has room after this tick's injection.
   assign inj_cw    = (arr_count != '0) && !req_payload.remote_cw_busy;
   assign inj_ccw   = (arr_count != '0) && req_payload.remote_cw_busy && remote_bidir_ff
                      && !req_payload.remote_ccw_busy;
   assign arr_pop   = inj_cw || inj_ccw;
   assign arr_after = arr_count - CNT_BITS'(arr_pop);
   assign arr_push  = link_valid_ff[LAST] && (arr_after < CNT_BITS'(BUF_DEPTH));

   // A stage is free this tick when it or any stage beyond it is empty, or when the far end
   // moves on. Each entry is an independent reduction over the stages above it.
   always_comb begin
      for (int i = 0; i < LINK_LATENCY; i++) begin
         free_vec[i] = arr_push;
         for (int j = i; j < LINK_LATENCY; j++) begin
            if (!link_valid_ff[j]) begin
               free_vec[i] = 1'b1;
            end
         end
      end
   end

   // Credits come back after the delay line, saturating at the full depth. A flit is sent
   // only into a free first stage and only while a credit remains; the reserved head flit has
   // priority over the eject queue.
   assign credit_ret      = credit_line_ff[LAST] && (credit_count_ff < CC_BITS'(CREDIT_DEPTH));
   assign credit_mid      = credit_count_ff + CC_BITS'(credit_ret);
   assign can_send        = free_vec[0] && (credit_mid != '0);
   assign send_res        = can_send && req_payload.reserved_head_valid;
   assign ej_pop          = can_send && !req_payload.reserved_head_valid && (ej_count != '0);
   assign send            = send_res || ej_pop;
   assign send_flit       = send_res ? req_payload.reserved_head_flit[FLIT_BITS-1:0] : ej_head;
   assign credit_count_in = credit_mid - CC_BITS'(send);

   always_comb begin
      link_valid_in = link_valid_ff;
      for (int i = 0; i < LINK_LATENCY; i++) begin
         link_flit_in[i] = link_flit_ff[i];
      end
      for (int i = 1; i < LINK_LATENCY; i++) begin
         if (free_vec[i]) begin
            link_valid_in[i] = link_valid_ff[i-1];
            link_flit_in[i]  = link_flit_ff[i-1];
         end
      end
      if (free_vec[0]) begin
         link_valid_in[0] = send;
         link_flit_in[0]  = send_flit;
      end
   end

   always_comb begin
      credit_line_in[0] = arr_pop;
      for (int i = 1; i < LINK_LATENCY; i++) begin
         credit_line_in[i] = credit_line_ff[i-1];
      end
   end

   // Local ejection. The clockwise slot is judged first, and the counterclockwise slot sees
   // the queue including any flit the clockwise slot has just pushed.
   assign ej_after    = ej_count - CNT_BITS'(ej_pop);
   assign cw_take     = req_payload.local_cw_occupied && req_payload.local_cw_to_remote
                        && (ej_after < CNT_BITS'(BUF_DEPTH));
   assign ej_after_cw = ej_after + CNT_BITS'(cw_take);
   assign ccw_take    = local_bidir_ff && req_payload.local_ccw_occupied
                        && req_payload.local_ccw_to_remote
                        && (ej_after_cw < CNT_BITS'(BUF_DEPTH));

   always_comb begin
      arr_ctrl.push0 = step && arr_push;
      arr_ctrl.push1 = 1'b0;
      arr_ctrl.pop   = step && arr_pop;
      ej_ctrl.push0  = step && cw_take;
      ej_ctrl.push1  = step && ccw_take;
      ej_ctrl.pop    = step && ej_pop;
   end

   crb_queue #(
      .DEPTH (BUF_DEPTH),
      .WIDTH (FLIT_BITS)
   ) u_arrival_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (arr_ctrl),
      .push0_data (link_flit_ff[LAST]),
      .push1_data ('0),
      .count      (arr_count),
      .head_data  (arr_head)
   );

   crb_queue #(
      .DEPTH (BUF_DEPTH),
      .WIDTH (FLIT_BITS)
   ) u_eject_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ej_ctrl),
      .push0_data (req_payload.local_cw_flit[FLIT_BITS-1:0]),
      .push1_data (req_payload.local_ccw_flit[FLIT_BITS-1:0]),
      .count      (ej_count),
      .head_data  (ej_head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff   <= '0;
         credit_line_ff  <= '0;
         credit_count_ff <= CC_BITS'(CREDIT_DEPTH);
      end else if (step) begin
         link_valid_ff   <= link_valid_in;
         credit_line_ff  <= credit_line_in;
         credit_count_ff <= credit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < LINK_LATENCY; i++) begin
            link_flit_ff[i] <= link_flit_in[i];
         end
      end
   end

   // Response of this tick. The injected flit and its direction read as zero when nothing
   // is injected.
   always_comb begin
      rsp_in.local_cw_taken  = cw_take;
      rsp_in.local_ccw_taken = ccw_take;
      rsp_in.inject_valid    = arr_pop;
      rsp_in.inject_ccw      = inj_ccw;
      rsp_in.inject_flit     = arr_pop ? crb_pkg::FLIT_FIELD_BITS'(arr_head) : '0;
      rsp_in.reserved_pop    = send_res;
      rsp_in.credits_left    = crb_pkg::CREDIT_FIELD_BITS'(credit_count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // Every credit is either held by the sender, riding the link, waiting in the arrival
   // queue or on its way back.
   a_credit_conservation : assert property (@(posedge clock) disable iff (reset)
      (int'(credit_count_ff) + $countones(link_valid_ff) + int'(arr_count)
       + $countones(credit_line_ff)) == CREDIT_DEPTH)
      else $error("credit count does not balance against flits in flight");

   a_queue_bounds : assert property (@(posedge clock) disable iff (reset)
      (arr_count <= CNT_BITS'(BUF_DEPTH)) && (ej_count <= CNT_BITS'(BUF_DEPTH)))
      else $error("queue fill exceeds its depth");

   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      step && send |=> credit_count_ff < CC_BITS'(CREDIT_DEPTH))
      else $error("a flit was sent without spending a credit");
`endif

endmodule
